@@ src/irc_line_tokenizer_core_defines.svh @@
// Assertion macros shared by the tokenizer RTL.
`ifndef IRC_LINE_TOKENIZER_CORE_DEFINES_SVH
`define IRC_LINE_TOKENIZER_CORE_DEFINES_SVH
`ifndef SYNTH
// same-cycle implication
`define IRCTOK_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("irctok assertion failed");
// next-cycle implication
`define IRCTOK_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("irctok assertion failed");
`else
`define IRCTOK_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define IRCTOK_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

@@ src/irctok_pkg.sv @@
package irctok_pkg;

  typedef struct packed {
    logic [7:0] line_byte;
    logic       end_of_line;
  } in_item_t;

  typedef struct packed {
    logic [2:0] token_kind;
    logic [4:0] param_index;
    logic [7:0] out_byte;
    logic       has_byte;
    logic       token_start;
    logic [2:0] command_code;
    logic [4:0] param_count;
    logic [1:0] line_status;
    logic       last_result;
  } out_item_t;

  // token kinds
  localparam logic [2:0] KIND_ORIGIN  = 3'd0;
  localparam logic [2:0] KIND_CMD     = 3'd1;
  localparam logic [2:0] KIND_PARAM   = 3'd2;
  localparam logic [2:0] KIND_TRAIL   = 3'd3;
  localparam logic [2:0] KIND_SUMMARY = 3'd4;

  // line status
  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_IGNORED = 2'd1;
  localparam logic [1:0] STATUS_NO_CMD  = 2'd2;

  // command codes
  localparam logic [2:0] CODE_UNKNOWN = 3'd0;

  // results one word can cause at most
  localparam int unsigned MAX_RESULTS = 3;

endpackage

@@ src/irctok_stream_if.sv @@
interface irctok_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ src/irctok_parser.sv @@
`include "irc_line_tokenizer_core_defines.svh"

module irctok_parser #(
  parameter int unsigned MAX_PARAMS = 19
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  irctok_pkg::in_item_t  item_i,
  output irctok_pkg::out_item_t res_o [irctok_pkg::MAX_RESULTS],
  output logic [1:0]            n_o
);
  import irctok_pkg::*;

  typedef enum logic [2:0] {
    PH_START, PH_ORIGIN, PH_CMD_BARE, PH_CMD_AFTER,
    PH_MSG_START, PH_PARAM, PH_TRAIL, PH_DISCARD
  } phase_e;

  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [4:0] LIMIT    = 5'(MAX_PARAMS);

  // PASS, PING, EOB, UID
  localparam logic [7:0] CMD_NAMES [4][4] = '{
    '{8'h50, 8'h41, 8'h53, 8'h53},
    '{8'h50, 8'h49, 8'h4E, 8'h47},
    '{8'h45, 8'h4F, 8'h42, 8'h00},
    '{8'h55, 8'h49, 8'h44, 8'h00}
  };
  localparam logic [2:0] CMD_LENS [4] = '{3'd4, 3'd4, 3'd3, 3'd3};

  function automatic out_item_t mk_tok(logic [2:0] kind, logic [4:0] idx,
                                       logic [7:0] b, logic has, logic start);
    out_item_t r;
    r             = '0;
    r.token_kind  = kind;
    r.param_index = idx;
    r.out_byte    = has ? b : 8'h00;
    r.has_byte    = has;
    r.token_start = start;
    return r;
  endfunction

  function automatic logic [3:0] mask_next(logic [2:0] len, logic [7:0] b,
                                           logic [3:0] mask);
    logic [3:0] m;
    logic [7:0] up;
    up = (b inside {[8'h61:8'h7A]}) ? (b - 8'd32) : b;
    m  = mask;
    for (int i = 0; i < 4; i++) begin
      if (len >= CMD_LENS[i] || CMD_NAMES[i][len[1:0]] != up) m[i] = 1'b0;
    end
    return m;
  endfunction

  function automatic logic [2:0] cmd_code(logic [2:0] len, logic [3:0] mask);
    logic [2:0] c;
    c = CODE_UNKNOWN;
    for (int i = 3; i >= 0; i--) begin
      if (mask[i] && len == CMD_LENS[i]) c = 3'(i + 1);
    end
    return c;
  endfunction

  phase_e     phase_q, phase_d;
  logic [4:0] params_q, params_d;
  logic       held_q, held_d;
  logic       run_q, run_d;
  logic [2:0] cmd_len_q, cmd_len_d;
  logic [3:0] cmd_mask_q, cmd_mask_d;
  logic       ignored_q, ignored_d;

  always_comb begin
    logic [7:0] b;
    logic [4:0] idx;
    logic [1:0] status;
    logic [1:0] n;
    b      = item_i.line_byte;
    idx    = (params_q != 5'd0) ? (params_q - 5'd1) : 5'd0;
    status = STATUS_OK;
    n      = 2'd0;
    for (int i = 0; i < MAX_RESULTS; i++) res_o[i] = '0;

    phase_d    = phase_q;
    params_d   = params_q;
    held_d     = held_q;
    run_d      = run_q;
    cmd_len_d  = cmd_len_q;
    cmd_mask_d = cmd_mask_q;
    ignored_d  = ignored_q;

    case (phase_q)
      PH_START: begin
        if (b == CH_NL) begin
          ignored_d = 1'b1;
          phase_d   = PH_DISCARD;
        end else if (b == CH_COLON) begin
          res_o[n] = mk_tok(KIND_ORIGIN, 5'd0, 8'h00, 1'b0, 1'b1); n = n + 2'd1;
          phase_d  = PH_ORIGIN;
        end else if (b == CH_SPACE) begin
          res_o[n] = mk_tok(KIND_CMD, 5'd0, 8'h00, 1'b0, 1'b1); n = n + 2'd1;
          phase_d  = PH_MSG_START;
        end else begin
          res_o[n]   = mk_tok(KIND_CMD, 5'd0, b, 1'b1, 1'b1); n = n + 2'd1;
          cmd_mask_d = mask_next(cmd_len_d, b, cmd_mask_d);
          cmd_len_d  = (cmd_len_d < 3'd7) ? cmd_len_d + 3'd1 : cmd_len_d;
          phase_d    = PH_CMD_BARE;
        end
      end
      PH_ORIGIN: begin
        if (b == CH_SPACE) phase_d = PH_CMD_AFTER;
        else begin
          res_o[n] = mk_tok(KIND_ORIGIN, 5'd0, b, 1'b1, 1'b0); n = n + 2'd1;
        end
      end
      PH_CMD_BARE, PH_CMD_AFTER: begin
        if (b == CH_SPACE) begin
          if (cmd_len_d == 3'd0) begin
            res_o[n] = mk_tok(KIND_CMD, 5'd0, 8'h00, 1'b0, 1'b1); n = n + 2'd1;
          end
          phase_d = PH_MSG_START;
        end else begin
          res_o[n]   = mk_tok(KIND_CMD, 5'd0, b, 1'b1, cmd_len_d == 3'd0);
          n          = n + 2'd1;
          cmd_mask_d = mask_next(cmd_len_d, b, cmd_mask_d);
          cmd_len_d  = (cmd_len_d < 3'd7) ? cmd_len_d + 3'd1 : cmd_len_d;
        end
      end
      PH_MSG_START: begin
        params_d = 5'd1;
        if (b == CH_COLON) begin
          res_o[n] = mk_tok(KIND_TRAIL, 5'd0, 8'h00, 1'b0, 1'b1); n = n + 2'd1;
          phase_d  = PH_TRAIL;
        end else if (b == CH_SPACE) begin
          res_o[n] = mk_tok(KIND_PARAM, 5'd0, 8'h00, 1'b0, 1'b1); n = n + 2'd1;
          run_d    = 1'b1;
          phase_d  = PH_PARAM;
        end else begin
          res_o[n] = mk_tok(KIND_PARAM, 5'd0, b, 1'b1, 1'b1); n = n + 2'd1;
          run_d    = 1'b0;
          phase_d  = PH_PARAM;
        end
      end
      PH_PARAM: begin
        if (params_q >= LIMIT) begin
          // last parameter: spaces are content, " :" ends the line
          if (!held_q) begin
            if (b == CH_SPACE) held_d = 1'b1;
            else begin
              res_o[n] = mk_tok(KIND_PARAM, idx, b, 1'b1, 1'b0); n = n + 2'd1;
            end
          end else if (b == CH_SPACE) begin
            res_o[n] = mk_tok(KIND_PARAM, idx, CH_SPACE, 1'b1, 1'b0); n = n + 2'd1;
          end else if (b == CH_COLON) begin
            held_d  = 1'b0;
            phase_d = PH_DISCARD;
          end else begin
            res_o[n] = mk_tok(KIND_PARAM, idx, CH_SPACE, 1'b1, 1'b0); n = n + 2'd1;
            res_o[n] = mk_tok(KIND_PARAM, idx, b, 1'b1, 1'b0); n = n + 2'd1;
            held_d   = 1'b0;
          end
        end else if (!run_q) begin
          if (b == CH_SPACE) run_d = 1'b1;
          else begin
            res_o[n] = mk_tok(KIND_PARAM, idx, b, 1'b1, 1'b0); n = n + 2'd1;
          end
        end else if (b == CH_COLON) begin
          res_o[n] = mk_tok(KIND_TRAIL, params_q, 8'h00, 1'b0, 1'b1); n = n + 2'd1;
          params_d = params_q + 5'd1;
          run_d    = 1'b0;
          phase_d  = PH_TRAIL;
        end else if (b != CH_SPACE) begin
          res_o[n] = mk_tok(KIND_PARAM, params_q, b, 1'b1, 1'b1); n = n + 2'd1;
          params_d = params_q + 5'd1;
          run_d    = 1'b0;
          held_d   = 1'b0;
        end
      end
      PH_TRAIL: begin
        res_o[n] = mk_tok(KIND_TRAIL, idx, b, 1'b1, 1'b0); n = n + 2'd1;
      end
      default: ;
    endcase

    if (item_i.end_of_line) begin
      case (phase_d)
        PH_ORIGIN, PH_CMD_BARE: status = STATUS_NO_CMD;
        PH_CMD_AFTER: begin
          if (cmd_len_d == 3'd0) begin
            res_o[n] = mk_tok(KIND_CMD, 5'd0, 8'h00, 1'b0, 1'b1); n = n + 2'd1;
          end
        end
        PH_MSG_START: begin
          res_o[n] = mk_tok(KIND_PARAM, 5'd0, 8'h00, 1'b0, 1'b1); n = n + 2'd1;
          params_d = 5'd1;
        end
        PH_PARAM: begin
          if (params_d >= LIMIT && held_d) begin
            res_o[n] = mk_tok(KIND_PARAM, params_d - 5'd1, CH_SPACE, 1'b1, 1'b0);
            n        = n + 2'd1;
          end
        end
        PH_DISCARD: if (ignored_d) status = STATUS_IGNORED;
        default: ;
      endcase

      res_o[n]              = mk_tok(KIND_SUMMARY, 5'd0, 8'h00, 1'b0, 1'b0);
      res_o[n].command_code = (status == STATUS_OK) ? cmd_code(cmd_len_d, cmd_mask_d)
                                                    : CODE_UNKNOWN;
      res_o[n].param_count  = (status == STATUS_OK) ? params_d : 5'd0;
      res_o[n].line_status  = status;
      res_o[n].last_result  = 1'b1;
      n                     = n + 2'd1;

      // back to reset values for the next line
      phase_d    = PH_START;
      params_d   = 5'd0;
      held_d     = 1'b0;
      run_d      = 1'b0;
      cmd_len_d  = 3'd0;
      cmd_mask_d = 4'hF;
      ignored_d  = 1'b0;
    end
    n_o = n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_START;
      params_q   <= 5'd0;
      held_q     <= 1'b0;
      run_q      <= 1'b0;
      cmd_len_q  <= 3'd0;
      cmd_mask_q <= 4'hF;
      ignored_q  <= 1'b0;
    end else if (accept_i) begin
      phase_q    <= phase_d;
      params_q   <= params_d;
      held_q     <= held_d;
      run_q      <= run_d;
      cmd_len_q  <= cmd_len_d;
      cmd_mask_q <= cmd_mask_d;
      ignored_q  <= ignored_d;
    end
  end

  `IRCTOK_ASSERT_IMP(a_eol_has_summary, clk_i, rst_ni, accept_i && item_i.end_of_line, n_o != 2'd0)
  `IRCTOK_ASSERT_NXT(a_eol_clears, clk_i, rst_ni, accept_i && item_i.end_of_line, phase_q == PH_START && params_q == 5'd0)
  `IRCTOK_ASSERT_IMP(a_params_bound, clk_i, rst_ni, 1'b1, params_q <= LIMIT)

endmodule

@@ src/irc_line_tokenizer_core.sv @@
// Results of an accepted word are registered into the result queue and reach
//   the output behind the results queued before them.
// Throughput: one input word per cycle while in_i.ready is high; results leave
//   one per cycle while out_o.ready is high, so the result queue sets the rate.
// Reset: rst_ni asynchronous, active low; parser returns to line start and
//   the result queue empties.
`include "irc_line_tokenizer_core_defines.svh"

module irc_line_tokenizer_core #(
  parameter int unsigned MAX_PARAMS = 19
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  irctok_stream_if.sink   in_i,
  irctok_stream_if.source out_o
);
  import irctok_pkg::*;

  // Result queue: four entries, head at slot 0. Up to three results are
  // appended per accepted word, one is popped per cycle while out_o.ready is high.
  localparam int unsigned QDEPTH = 4;

  out_item_t  res [MAX_RESULTS];
  logic [1:0] res_n;

  out_item_t  q_q [QDEPTH];
  out_item_t  q_d [QDEPTH];
  logic [2:0] occ_q, occ_d;
  logic [2:0] base;
  logic       pop;
  logic       in_acc;

  assign pop         = (occ_q != 3'd0) && out_o.ready;
  // occupancy left after this cycle's pop
  assign base        = occ_q - {2'b00, pop};
  // take a word only if its worst case of three results still fits
  assign in_i.ready  = (base <= 3'd1);
  assign in_acc      = in_i.valid && in_i.ready;

  assign out_o.valid = (occ_q != 3'd0);
  assign out_o.data  = q_q[0];

  irctok_parser #(
    .MAX_PARAMS(MAX_PARAMS)
  ) u_parser (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(in_acc),
    .item_i  (in_i.data),
    .res_o   (res),
    .n_o     (res_n)
  );

  always_comb begin
    logic [2:0] rel;
    for (int i = 0; i < QDEPTH; i++) begin
      // shift toward the head on a pop
      q_d[i] = (pop && i < QDEPTH - 1) ? q_q[2'(i + 1)] : q_q[i];
      rel    = 3'(i) - base;
      // append new results behind what stays
      if (in_acc && 3'(i) >= base && rel < {1'b0, res_n}) q_d[i] = res[rel[1:0]];
    end
    occ_d = base + (in_acc ? {1'b0, res_n} : 3'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 3'd0;
    end else begin
      occ_q <= occ_d;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < QDEPTH; i++) q_q[i] <= q_d[i];
  end

  `IRCTOK_ASSERT_IMP(a_occ_bound, clk_i, rst_ni, 1'b1, occ_q <= 3'(QDEPTH))
  `IRCTOK_ASSERT_IMP(a_last_is_summary, clk_i, rst_ni, out_o.valid && out_o.data.last_result, out_o.data.token_kind == KIND_SUMMARY && !out_o.data.has_byte)
  `IRCTOK_ASSERT_NXT(a_pop_drains, clk_i, rst_ni, pop && !in_acc, occ_q == $past(occ_q) - 3'd1)

endmodule
